### rtl/psa_pkg.sv
// ---------------------------------------------------------------------------
// psa_pkg: shared types and constants for the paged slot allocator
// Holds page memory layout, command and status codes and the control states.
// ---------------------------------------------------------------------------
package psa_pkg;

    localparam int PAGE_COUNT = 256;
    localparam int SLOT_COUNT = 64;

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LINK_W = PAGE_W + 1;
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);

    localparam logic [LINK_W-1:0] LIST_NONE = LINK_W'(PAGE_COUNT);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_OPEN     = 1'b1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CHECK_ALT = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_CLOSED  = 3'd1,
        STS_BADADDR = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_NOPAGE  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] slot_map;
        logic [FILL_W-1:0]     fill;
        logic [LINK_W-1:0]     link;
    } t_page_entry;

    localparam int ENTRY_W = $bits(t_page_entry);

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_find;

endpackage

### rtl/psa_page_ram.sv
// ---------------------------------------------------------------------------
// psa_page_ram: simple dual-port page memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module psa_page_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/psa_slot_find.sv
// ---------------------------------------------------------------------------
// psa_slot_find: lowest clear slot search
// Masks the occupancy map to the usable slots and encodes the lowest free one.
// ---------------------------------------------------------------------------
module psa_slot_find (
    input  logic [psa_pkg::SLOT_COUNT-1:0] i_slot_map,
    input  logic [psa_pkg::FILL_W-1:0]     i_usable,
    output psa_pkg::t_find                 o_find
);
    import psa_pkg::*;

    logic [SLOT_COUNT-1:0] free_bits;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            free_bits[i] = !i_slot_map[i] && (FILL_W'(i) < i_usable);
        end
    end

    always_comb begin
        o_find.found = |free_bits;
        o_find.slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                o_find.slot = SLOT_W'(i);
            end
        end
    end

endmodule

### rtl/paged_slot_allocator.sv
// ---------------------------------------------------------------------------
// paged_slot_allocator: bitmap slot allocator with a free page list
// Page bitmaps, fill counts and free links sit in one page memory.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_valid / o_stall with i_cmd, i_page_number and
//   i_slot_number; every request gives exactly one result on o_valid /
//   i_stall (status, page, slot, occupied).
//   On the accept edge the page entry (head free page for insert,
//   addressed page otherwise) is read from the page memory into its
//   registered read port; the modify state then modifies the entry, writes
//   it back, updates the list head and page counter and loads the result
//   register. The read-modify-write of the single page memory and the list
//   head hold off the next request until the modify state is done.
//   A new request is taken while the previous result waits in the output
//   register; if that result is still stalled, the modify cycle holds until
//   the output register frees up.
//   Reset empties the free list and opens no pages; no memory clearing is
//   needed since a page entry is written in full when the page is opened.
//   slots_per_page resets to 64, store_open to 1. Configuration is written by
//   the user via i_cfg_we / i_cfg_index / i_cfg_data while the block is idle; not enforced.
// ---------------------------------------------------------------------------
module paged_slot_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_cmd,
    input  logic [psa_pkg::PAGE_W-1:0]     i_page_number,
    input  logic [psa_pkg::SLOT_W-1:0]     i_slot_number,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_status,
    output logic [psa_pkg::PAGE_W-1:0]     o_result_page,
    output logic [psa_pkg::SLOT_W-1:0]     o_result_slot,
    output logic                           o_occupied,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psa_pkg::*;

    t_state r_state, n_state;

    logic [FILL_W-1:0] r_slots_cfg;
    logic              r_store_open;

    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_pages, n_pages;

    t_cmd              r_cmd;
    logic [PAGE_W-1:0] r_page;
    logic [SLOT_W-1:0] r_slot;

    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [PAGE_W-1:0] r_res_page, n_res_page;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic              r_occupied, n_occupied;

    logic              accept;
    logic              out_free;
    logic [PAGE_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    t_page_entry       rd_entry;
    t_page_entry       cur_entry;
    t_page_entry       wr_entry;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    logic [PAGE_W-1:0] ins_page;
    logic [FILL_W-1:0] usable;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] fill_dec;
    logic              fresh;
    t_find             find;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // insert reads the head page, delete and check the addressed page
    assign rd_addr = (t_cmd'(i_cmd) == CMD_INSERT) ? r_head[PAGE_W-1:0] : i_page_number;

    psa_page_ram #(
        .DEPTH (PAGE_COUNT),
        .WIDTH (ENTRY_W)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_page_entry'(rd_data);

    always_comb begin
        if (r_slots_cfg == '0) begin
            usable = FILL_W'(1);
        end else if (r_slots_cfg > FILL_W'(SLOT_COUNT)) begin
            usable = FILL_W'(SLOT_COUNT);
        end else begin
            usable = r_slots_cfg;
        end
    end

    // an empty list opens the next sequential page with a blank entry
    assign fresh    = r_head[PAGE_W];
    assign ins_page = fresh ? r_pages[PAGE_W-1:0] : r_head[PAGE_W-1:0];

    always_comb begin
        if (fresh && r_cmd == CMD_INSERT) begin
            cur_entry.slot_map = '0;
            cur_entry.fill     = '0;
            cur_entry.link     = LIST_NONE;
        end else begin
            cur_entry = rd_entry;
        end
    end

    psa_slot_find u_slot_find (
        .i_slot_map (cur_entry.slot_map),
        .i_usable   (usable),
        .o_find     (find)
    );

    assign fill_inc = (cur_entry.fill < FILL_W'(SLOT_COUNT)) ?
                      cur_entry.fill + FILL_W'(1) : cur_entry.fill;
    assign fill_dec = (cur_entry.fill != '0) ? cur_entry.fill - FILL_W'(1) : '0;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_pages     = r_pages;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_res_page  = r_res_page;
        n_res_slot  = r_res_slot;
        n_occupied  = r_occupied;
        wr_en       = 1'b0;
        wr_addr     = r_page;
        wr_entry    = cur_entry;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_res_page  = r_page;
                    n_res_slot  = r_slot;
                    n_occupied  = 1'b0;
                    if (!r_store_open) begin
                        n_status = STS_CLOSED;
                        if (r_cmd == CMD_INSERT) begin
                            n_res_page = '0;
                            n_res_slot = '0;
                        end
                    end else if (r_cmd == CMD_INSERT) begin
                        n_res_page = '0;
                        n_res_slot = '0;
                        if (fresh && r_pages[PAGE_W]) begin
                            n_status = STS_NOPAGE;
                        end else if (!find.found) begin
                            // head page full after the slot count shrank
                            n_status = STS_NOPAGE;
                            n_head   = cur_entry.link;
                            if (fresh) begin
                                n_pages = r_pages + LINK_W'(1);
                            end
                        end else begin
                            n_status   = STS_OK;
                            n_res_page = ins_page;
                            n_res_slot = find.slot;
                            n_occupied = 1'b1;
                            if (fresh) begin
                                n_pages = r_pages + LINK_W'(1);
                                n_head  = {1'b0, ins_page};
                            end
                            wr_en    = 1'b1;
                            wr_addr  = ins_page;
                            wr_entry.slot_map[find.slot] = 1'b1;
                            wr_entry.fill = fill_inc;
                            if (fill_inc >= usable) begin
                                n_head = cur_entry.link;
                            end
                        end
                    end else if ({1'b0, r_page} >= r_pages ||
                                 FILL_W'(r_slot) >= usable) begin
                        n_status = STS_BADADDR;
                    end else if (!cur_entry.slot_map[r_slot]) begin
                        n_status = STS_EMPTY;
                    end else if (r_cmd == CMD_DELETE) begin
                        n_status = STS_OK;
                        wr_en    = 1'b1;
                        wr_entry.slot_map[r_slot] = 1'b0;
                        wr_entry.fill = fill_dec;
                        // page leaves the full state: push it on the list
                        if (fill_dec == usable - FILL_W'(1)) begin
                            wr_entry.link = r_head;
                            n_head        = {1'b0, r_page};
                        end
                    end else begin
                        n_status   = STS_OK;
                        n_occupied = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= LIST_NONE;
            r_pages      <= '0;
            r_out_valid  <= 1'b0;
            r_slots_cfg  <= FILL_W'(SLOT_COUNT);
            r_store_open <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_pages     <= n_pages;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS_PER_PAGE: r_slots_cfg  <= i_cfg_data;
                    CFG_STORE_OPEN:     r_store_open <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_page <= i_page_number;
            r_slot <= i_slot_number;
        end
        r_status   <= n_status;
        r_res_page <= n_res_page;
        r_res_slot <= n_res_slot;
        r_occupied <= n_occupied;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_result_page = r_res_page;
    assign o_result_slot = r_res_slot;
    assign o_occupied    = r_occupied;

    // the list head always names an opened page or the empty marker
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == LIST_NONE) || (r_head < r_pages))
        else $error("free list head points past opened pages");

    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= LINK_W'(PAGE_COUNT))
        else $error("page counter overflow");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("accepted request did not enter modify cycle");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && out_free) |=> (r_state == S_IDLE && o_valid))
        else $error("modify cycle did not produce a result");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_EXEC && r_store_open))
        else $error("page memory written outside modify cycle");

endmodule
